@@ design/sdeq_pkg.sv @@
// Shared constants and codes for the sorted double-ended queue.
package sdeq_pkg;

	localparam int unsigned CAPACITY_DEF = 64;
	localparam int unsigned DATA_W       = 32;
	localparam int unsigned COUNT_OUT_W  = 7;

	typedef enum logic [1:0] {
		CMD_INSERT  = 2'd0,
		CMD_REM_MIN = 2'd1,
		CMD_REM_MAX = 2'd2,
		CMD_NOP     = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;

endpackage

@@ design/sdeq_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
module sdeq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ design/sorted_double_ended_queue_top.sv @@
// Sorted double-ended queue: ascending store of signed values in one RAM.
//
// Usage:
//   Input channel (in_valid / in_stall) carries command and value. Output
//   channel (out_valid / out_stall) returns one beat per command with status,
//   removed_value and entry_count. Commands: insert, remove smallest, remove
//   largest; the unused code does nothing and reports the count.
//   Values live in a circular buffer in one RAM; removing the smallest moves
//   the head pointer, removing the largest shrinks the count.
//   A remove passes through S_RDWAIT and S_DONE; a refused command or the
//   unused code goes straight to S_DONE. An insert binary-searches the store
//   (up to clog2(count+1) steps), moves every entry at and above the insert
//   point up by one (one entry at a time, one read port), writes the value
//   and reports through S_DONE.
//   One command is in flight at a time; in_stall is high while it is worked,
//   so the next command is taken in the same cycle the result turns valid.
//   A finished result sits in the output register, so the next command is
//   taken while the previous result is still stalled; the block then waits
//   at the end of that command until the output register is free.
//   Reset empties the store at once (count and head cleared, no RAM sweep).
module sorted_double_ended_queue_top #(
	parameter int unsigned CAPACITY = sdeq_pkg::CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] removed_value,
	output logic [6:0]  entry_count
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned DW = sdeq_pkg::DATA_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SRCH,
		S_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_INS,
		S_RDWAIT,
		S_DONE
	} state_t;

	state_t            state_q;
	sdeq_pkg::cmd_t    cmd_q;
	sdeq_pkg::status_t stat_q;
	logic [DW-1:0]     val_q;
	logic [DW-1:0]     rem_q;
	logic [AW-1:0]     head_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     lo_q;
	logic [CW-1:0]     hi_q;
	logic [CW-1:0]     idx_q;

	logic              out_valid_q;
	logic [1:0]        status_q;
	logic [DW-1:0]     removed_q;
	logic [6:0]        entry_count_q;

	logic              ram_wr_en;
	logic [AW-1:0]     ram_wr_addr;
	logic [DW-1:0]     ram_wr_data;
	logic              ram_rd_en;
	logic [AW-1:0]     ram_rd_addr;
	logic [DW-1:0]     ram_rd_data;

	logic              accept;
	logic              out_free;
	logic [CW-1:0]     mid;
	logic [CW:0]       mid_sum;
	logic              is_full;
	logic              is_empty;

	// Map a logical position to its RAM address around the head.
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [CW-1:0] l);
		logic [AW:0] s;
		s = {1'b0, hd} + {1'b0, AW'(l)};
		if (s >= (AW+1)'(CAPACITY)) begin
			s = s - (AW+1)'(CAPACITY);
		end
		return s[AW-1:0];
	endfunction

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid      = mid_sum[CW:1];
	assign is_full  = (count_q == CW'(CAPACITY));
	assign is_empty = (count_q == '0);

	always_comb begin
		ram_rd_en   = 1'b0;
		ram_rd_addr = '0;
		ram_wr_en   = 1'b0;
		ram_wr_addr = '0;
		ram_wr_data = val_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && !is_empty) begin
					if (command == sdeq_pkg::CMD_REM_MIN) begin
						ram_rd_en   = 1'b1;
						ram_rd_addr = head_q;
					end else if (command == sdeq_pkg::CMD_REM_MAX) begin
						ram_rd_en   = 1'b1;
						ram_rd_addr = phys(head_q, CW'(count_q - CW'(1)));
					end
				end
			end
			S_SRCH: begin
				if (lo_q != hi_q) begin
					ram_rd_en   = 1'b1;
					ram_rd_addr = phys(head_q, mid);
				end
			end
			S_SHIFT_RD: begin
				if (idx_q != lo_q) begin
					ram_rd_en   = 1'b1;
					ram_rd_addr = phys(head_q, CW'(idx_q - CW'(1)));
				end
			end
			S_SHIFT_WR: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = phys(head_q, idx_q);
				ram_wr_data = ram_rd_data;
			end
			S_INS: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = phys(head_q, lo_q);
				ram_wr_data = val_q;
			end
			S_CMP, S_RDWAIT, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	sdeq_ram #(
		.WIDTH (DW),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			head_q        <= '0;
			count_q       <= '0;
			out_valid_q   <= 1'b0;
			cmd_q         <= sdeq_pkg::CMD_NOP;
			stat_q        <= sdeq_pkg::ST_DONE;
			val_q         <= '0;
			rem_q         <= '0;
			lo_q          <= '0;
			hi_q          <= '0;
			idx_q         <= '0;
			status_q      <= '0;
			removed_q     <= '0;
			entry_count_q <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q  <= sdeq_pkg::cmd_t'(command);
						val_q  <= value;
						rem_q  <= '0;
						stat_q <= sdeq_pkg::ST_DONE;
						lo_q   <= '0;
						hi_q   <= count_q;
						case (sdeq_pkg::cmd_t'(command))
							sdeq_pkg::CMD_INSERT: begin
								if (is_full) begin
									stat_q  <= sdeq_pkg::ST_FULL;
									state_q <= S_DONE;
								end else begin
									state_q <= S_SRCH;
								end
							end
							sdeq_pkg::CMD_REM_MIN, sdeq_pkg::CMD_REM_MAX: begin
								if (is_empty) begin
									stat_q  <= sdeq_pkg::ST_EMPTY;
									state_q <= S_DONE;
								end else begin
									state_q <= S_RDWAIT;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_SRCH: begin
					// search done: lo holds the first entry not less than the value
					if (lo_q == hi_q) begin
						idx_q   <= count_q;
						state_q <= S_SHIFT_RD;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if ($signed(ram_rd_data) < $signed(val_q)) begin
						lo_q <= CW'(mid + CW'(1));
					end else begin
						hi_q <= mid;
					end
					state_q <= S_SRCH;
				end
				S_SHIFT_RD: begin
					if (idx_q == lo_q) begin
						state_q <= S_INS;
					end else begin
						state_q <= S_SHIFT_WR;
					end
				end
				S_SHIFT_WR: begin
					idx_q   <= CW'(idx_q - CW'(1));
					state_q <= S_SHIFT_RD;
				end
				S_INS: begin
					count_q <= CW'(count_q + CW'(1));
					state_q <= S_DONE;
				end
				S_RDWAIT: begin
					rem_q   <= ram_rd_data;
					count_q <= CW'(count_q - CW'(1));
					if (cmd_q == sdeq_pkg::CMD_REM_MIN) begin
						head_q <= phys(head_q, CW'(1));
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hold until the output register can take the beat
					if (out_free) begin
						out_valid_q   <= 1'b1;
						status_q      <= stat_q;
						removed_q     <= rem_q;
						entry_count_q <= 7'(count_q);
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign removed_value = removed_q;
	assign entry_count   = entry_count_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count exceeds capacity");

	a_search_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRCH || state_q == S_CMP) |-> (lo_q <= hi_q && hi_q <= count_q))
		else $error("search bounds out of order");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == sdeq_pkg::ST_FULL) |-> (entry_count == 7'(CAPACITY)))
		else $error("full status with store not full");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == sdeq_pkg::ST_EMPTY) |->
		(entry_count == '0 && removed_value == '0))
		else $error("empty status with nonzero count or value");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS) |=> (count_q == CW'($past(count_q) + CW'(1))))
		else $error("insert did not grow the count");
`endif

endmodule
